### sv/cra_pkg.sv
package cra_pkg;

  localparam logic [2:0] MODE_AVG = 3'd0;
  localparam logic [2:0] MODE_TOTAL = 3'd1;
  localparam logic [2:0] MODE_MAX = 3'd2;
  localparam logic [2:0] MODE_MIN = 3'd3;
  localparam logic [2:0] MODE_MAJ = 3'd4;
  localparam logic [2:0] MODE_MINOR = 3'd5;

  localparam int SUM_W = 40;
  localparam logic signed [SUM_W-1:0] SUM_MAX = {1'b0, {(SUM_W-1){1'b1}}};
  localparam logic signed [SUM_W-1:0] SUM_MIN = {1'b1, {(SUM_W-1){1'b0}}};

  // Request from the control sequencer to the divider.
  typedef struct packed {
    logic start;
    logic signed [SUM_W-1:0] dividend;
  } div_req_t;

endpackage

### sv/cra_div.sv
// Signed truncating divide, one quotient bit per cycle.
module cra_div #(
  parameter int CW = 9
) (
  input  logic clk,
  input  logic rst,
  input  cra_pkg::div_req_t req,
  input  logic [CW-1:0] divisor,
  output logic busy,
  output logic done,
  output logic signed [cra_pkg::SUM_W-1:0] quotient
);
  localparam int W = cra_pkg::SUM_W;
  localparam int CNT_W = $clog2(W + 1);

  logic [W-1:0] quo;
  logic [CW:0] rem;
  logic [CW-1:0] dvs;
  logic neg;
  logic [CNT_W-1:0] cnt;
  logic [CW:0] shifted;
  logic [CW:0] diff;

  assign shifted = {rem[CW-1:0], quo[W-1]};
  assign diff = shifted - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt <= CNT_W'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      neg <= req.dividend[W-1];
      quo <= req.dividend[W-1] ? (W)'(-req.dividend) : req.dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      if (!diff[CW]) begin
        rem <= diff;
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= shifted;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

  assign quotient = neg ? -$signed(quo) : $signed(quo);
endmodule

### sv/cell_record_aggregator.sv
// Channel   | Signals                                   | Direction
// record    | valid, ready, value, last_of_cell, empty_cell | in, ready out
// aggregate | out_valid, out_ready, result, missing, conflict, overflow | out, out_ready in
// config    | APB: psel penable pwrite paddr pwdata prdata pready | in/out
//
// A record is looked up by reading table entries in order; a match updates that entry,
// otherwise a new value takes a free entry. A record past the limit is dropped and sets overflow.
// A closing record then passes through a state that selects the result. Majority or minority
// then reads the table twice more, and an average waits on the divider.
// Reset is synchronous and clears the group state at once.
// The result register holds until out_ready; a new request is taken only
// when it is free.
module cell_record_aggregator #(
  parameter int DISTINCT = 16,
  parameter int MAX_RECORDS = 256
) (
  input  logic clk,
  input  logic rst,
  input  logic valid,
  output logic ready,
  input  logic signed [31:0] value,
  input  logic last_of_cell,
  input  logic empty_cell,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [39:0] result,
  output logic missing,
  output logic conflict,
  output logic overflow,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [1:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  localparam int IW = $clog2(DISTINCT);
  localparam int UW = $clog2(DISTINCT + 1);
  localparam int CW = $clog2(MAX_RECORDS + 1);
  localparam int W = cra_pkg::SUM_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRCH = 3'd1;
  localparam logic [2:0] S_UPD = 3'd2;
  localparam logic [2:0] S_SCAN = 3'd3;
  localparam logic [2:0] S_TIE = 3'd4;
  localparam logic [2:0] S_DIV = 3'd5;
  localparam logic [2:0] S_CLOSE = 3'd6;

  logic [2:0] mode;
  logic [2:0] state;

  // Table memories: value and count per entry.
  logic [31:0] vmem [DISTINCT];
  logic [CW-1:0] cmem [DISTINCT];
  logic [31:0] vrd;
  logic [CW-1:0] crd;
  logic [IW-1:0] raddr;
  logic re;
  logic we;
  logic [IW-1:0] waddr;
  logic [31:0] wval;
  logic [CW-1:0] wcnt;

  logic signed [W-1:0] sum;
  logic [CW-1:0] count;
  logic signed [31:0] rmin;
  logic signed [31:0] rmax;
  logic [UW-1:0] used;
  logic ovf;

  logic signed [31:0] cur;
  logic cur_last;
  logic [UW-1:0] idx;
  logic [IW-1:0] hit_idx;
  logic rd_pending;
  logic [IW-1:0] rd_idx;
  logic signed [31:0] best_v;
  logic [CW-1:0] best_c;
  logic tie;
  logic pass2;

  cra_pkg::div_req_t dreq;
  logic dbusy;
  logic ddone;
  logic signed [W-1:0] quot;

  assign pready = 1'b1;
  assign prdata = {29'd0, mode};
  assign ready = (state == S_IDLE) && !out_valid;

  always_ff @(posedge clk) begin
    if (rst) mode <= cra_pkg::MODE_AVG;
    else if (psel && penable && pwrite && paddr == 2'd0) mode <= pwdata[2:0];
  end

  // The read address comes straight from the walk index so the data of the
  // entry at rd_idx is on vrd/crd in the cycle after its read is issued.
  always_comb begin
    re = 1'b0;
    raddr = idx[IW-1:0];
    if (state == S_SRCH) re = !(rd_pending && vrd == cur) && (idx != used);
    else if (state == S_SCAN) re = (idx != used);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      vmem[waddr] <= wval;
      cmem[waddr] <= wcnt;
    end
    if (re) begin
      vrd <= vmem[raddr];
      crd <= cmem[raddr];
    end
  end

  cra_div #(.CW(CW)) u_div (
    .clk(clk), .rst(rst), .req(dreq), .divisor(count),
    .busy(dbusy), .done(ddone), .quotient(quot)
  );

  logic signed [W:0] sum_ext;
  logic signed [W-1:0] sum_sat;
  logic sat;
  logic better;
  logic maj;

  assign sum_ext = {sum[W-1], sum} + (W+1)'(cur);
  always_comb begin
    sat = 1'b0;
    sum_sat = sum_ext[W-1:0];
    if (sum_ext > (W+1)'(cra_pkg::SUM_MAX)) begin
      sum_sat = cra_pkg::SUM_MAX;
      sat = 1'b1;
    end else if (sum_ext < $signed({cra_pkg::SUM_MIN[W-1], cra_pkg::SUM_MIN})) begin
      sum_sat = cra_pkg::SUM_MIN;
      sat = 1'b1;
    end
  end

  assign maj = (mode == cra_pkg::MODE_MAJ);
  always_comb begin
    if (maj) better = (crd > best_c) || (crd == best_c && $signed(vrd) > best_v);
    else better = (crd < best_c) || (crd == best_c && $signed(vrd) < best_v);
  end

  task automatic finish(input logic signed [W-1:0] r, input logic c);
    result <= r;
    missing <= 1'b0;
    conflict <= c;
    overflow <= ovf;
    out_valid <= 1'b1;
  endtask

  always_ff @(posedge clk) begin
    dreq.start <= 1'b0;
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
      sum <= '0;
      count <= '0;
      rmin <= '0;
      rmax <= '0;
      used <= '0;
      ovf <= 1'b0;
      rd_pending <= 1'b0;
      dreq.start <= 1'b0;
      we <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (valid && ready) begin
            cur <= value;
            cur_last <= last_of_cell;
            if (empty_cell) begin
              sum <= '0; count <= '0; rmin <= '0; rmax <= '0;
              used <= '0; ovf <= 1'b0;
              result <= '0; missing <= 1'b1; conflict <= 1'b0;
              overflow <= 1'b0; out_valid <= 1'b1;
            end else if (count == CW'(MAX_RECORDS)) begin
              ovf <= 1'b1;
              state <= last_of_cell ? S_CLOSE : S_IDLE;
            end else begin
              idx <= '0;
              rd_pending <= 1'b0;
              state <= S_SRCH;
            end
          end
        end
        S_SRCH: begin
          // Issue one read a cycle; compare the previous read's data.
          if (rd_pending && vrd == cur) begin
            hit_idx <= rd_idx;
            rd_pending <= 1'b0;
            state <= S_UPD;
          end else if (idx == used) begin
            if (!rd_pending) begin
              if (used == UW'(DISTINCT)) begin
                ovf <= 1'b1;
                state <= cur_last ? S_CLOSE : S_IDLE;
              end else begin
                we <= 1'b1;
                waddr <= used[IW-1:0];
                wval <= cur;
                wcnt <= CW'(1);
                used <= used + 1'b1;
                sum <= sum_sat;
                if (sat) ovf <= 1'b1;
                rmin <= (count == '0 || cur < rmin) ? cur : rmin;
                rmax <= (count == '0 || cur > rmax) ? cur : rmax;
                count <= count + 1'b1;
                state <= cur_last ? S_CLOSE : S_IDLE;
              end
            end
            rd_pending <= 1'b0;
          end else begin
            rd_idx <= idx[IW-1:0];
            rd_pending <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_UPD: begin
          we <= 1'b1;
          waddr <= hit_idx;
          wval <= cur;
          wcnt <= crd + 1'b1;
          sum <= sum_sat;
          if (sat) ovf <= 1'b1;
          rmin <= (cur < rmin) ? cur : rmin;
          rmax <= (cur > rmax) ? cur : rmax;
          count <= count + 1'b1;
          state <= cur_last ? S_CLOSE : S_IDLE;
        end
        S_CLOSE: begin
          if (count == '0) begin
            result <= '0; missing <= 1'b1; conflict <= 1'b0;
            overflow <= ovf; out_valid <= 1'b1;
            state <= S_IDLE;
            sum <= '0; used <= '0; ovf <= 1'b0;
          end else begin
            priority case (mode)
              cra_pkg::MODE_TOTAL: begin finish(sum, 1'b0); state <= S_IDLE; end
              cra_pkg::MODE_MAX: begin finish(W'(rmax), 1'b0); state <= S_IDLE; end
              cra_pkg::MODE_MIN: begin finish(W'(rmin), 1'b0); state <= S_IDLE; end
              cra_pkg::MODE_MAJ, cra_pkg::MODE_MINOR: begin
                idx <= '0; rd_pending <= 1'b0; pass2 <= 1'b0; tie <= 1'b0;
                state <= S_SCAN;
              end
              default: begin
                dreq.start <= 1'b1;
                dreq.dividend <= sum;
                state <= S_DIV;
              end
            endcase
            if (mode != cra_pkg::MODE_MAJ && mode != cra_pkg::MODE_MINOR &&
                mode == cra_pkg::MODE_TOTAL || mode == cra_pkg::MODE_MAX ||
                mode == cra_pkg::MODE_MIN) begin
              sum <= '0; count <= '0; rmin <= '0; rmax <= '0;
              used <= '0; ovf <= 1'b0;
            end
          end
        end
        S_SCAN: begin
          // First pass finds the winner, second pass checks for a tie.
          if (rd_pending) begin
            if (!pass2) begin
              if (rd_idx == '0 || better) begin
                best_v <= vrd;
                best_c <= crd;
              end
            end else if (crd == best_c && $signed(vrd) != best_v) begin
              tie <= 1'b1;
            end
          end
          if (idx == used) begin
            rd_pending <= 1'b0;
            if (!rd_pending) begin
              if (!pass2) begin
                pass2 <= 1'b1;
                idx <= '0;
              end else begin
                state <= S_TIE;
              end
            end
          end else begin
            rd_idx <= idx[IW-1:0];
            rd_pending <= 1'b1;
            idx <= idx + 1'b1;
          end
        end
        S_TIE: begin
          finish(W'(best_v), tie);
          sum <= '0; count <= '0; rmin <= '0; rmax <= '0;
          used <= '0; ovf <= 1'b0;
          state <= S_IDLE;
        end
        S_DIV: begin
          if (ddone) begin
            finish(quot, 1'b0);
            sum <= '0; count <= '0; rmin <= '0; rmax <= '0;
            used <= '0; ovf <= 1'b0;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  logic unused_busy;
  assign unused_busy = dbusy;
endmodule

### sv/cra_checker.sv
module cra_checker (
  input logic clk,
  input logic rst,
  input logic ready,
  input logic out_valid,
  input logic out_ready,
  input logic missing,
  input logic conflict,
  input logic pready
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result dropped");
  a_no_take_full: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !ready) else $error("request taken while result waits");
  a_miss_noconf: assert property (@(posedge clk) disable iff (rst)
    out_valid && missing |-> !conflict) else $error("missing with conflict");
  a_pready: assert property (@(posedge clk) pready) else $error("pready low");
  a_reset: assert property (@(posedge clk) $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind cell_record_aggregator cra_checker u_chk (
  .clk(clk), .rst(rst), .ready(ready), .out_valid(out_valid),
  .out_ready(out_ready), .missing(missing), .conflict(conflict), .pready(pready)
);
